@@ hdl/wlr_pkg.sv @@
package wlr_pkg;

	// Default map size and the longest line that is traced.
	localparam int GRID_COLS_DEF = 64;
	localparam int GRID_ROWS_DEF = 32;
	localparam int MAX_STEPS     = 32;
	localparam int STEP_W        = $clog2(MAX_STEPS + 1);

	localparam int COL_W = 6;
	localparam int ROW_W = 5;

	typedef struct packed {
		logic [COL_W-1:0] start_x;
		logic [ROW_W-1:0] start_y;
		logic [COL_W-1:0] end_x;
		logic [ROW_W-1:0] end_y;
	} line_t;

	typedef struct packed {
		logic [COL_W-1:0]  point_x;
		logic [ROW_W-1:0]  point_y;
		logic [STEP_W-1:0] step_number;
		logic              is_last;
	} point_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic delta;
		logic span;
		logic reduce;
		logic step;
	} wlr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic x_ok;
		logic last;
	} wlr_status_t;

endpackage

@@ hdl/wlr_ctrl.sv @@
module wlr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                line_valid,
	output logic                line_stall,
	output logic                point_valid,
	input  logic                point_stall,
	input  wlr_pkg::wlr_status_t status,
	output wlr_pkg::wlr_cmd_t    cmd
);
	import wlr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_SPAN,
		ST_REDUCE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   point_valid_q;
	logic   can_emit;

	// The output register can take a new point when it is empty or being emptied.
	assign can_emit = !point_valid_q || !point_stall;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && line_valid;
		cmd.delta  = (state_q == ST_DELTA);
		cmd.span   = (state_q == ST_SPAN);
		cmd.reduce = (state_q == ST_DELTA) || (state_q == ST_SPAN) ||
			(state_q == ST_REDUCE);
		cmd.step   = (state_q == ST_RUN) && can_emit;
	end

	assign line_stall  = (state_q != ST_IDLE);
	assign point_valid = point_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_valid_q <= 1'b0;
		end else begin
			if (cmd.step) begin
				point_valid_q <= 1'b1;
			end else if (!point_stall) begin
				point_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (line_valid) begin
						state_q <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					state_q <= ST_SPAN;
				end
				ST_SPAN: begin
					state_q <= status.x_ok ? ST_RUN : ST_REDUCE;
				end
				ST_REDUCE: begin
					if (status.x_ok) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (can_emit && status.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/wlr_datapath.sv @@
module wlr_datapath #(
	parameter int GRID_COLS = wlr_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = wlr_pkg::GRID_ROWS_DEF
) (
	input  logic                 clk,
	input  wlr_pkg::wlr_cmd_t    cmd,
	input  wlr_pkg::line_t       line,
	output wlr_pkg::wlr_status_t status,
	output wlr_pkg::point_t      point
);
	import wlr_pkg::*;

	localparam int DMAX  = (GRID_COLS > 63) ? GRID_COLS : 63;
	localparam int DXW   = $clog2(DMAX + 1) + 1;
	localparam int SW    = DXW - 1;
	localparam int RW    = SW + 3;
	localparam int XW    = $clog2(((GRID_COLS > 64) ? GRID_COLS : 64) + 1);
	localparam int YW    = ($clog2(GRID_ROWS) + 1 > 7) ?
		$clog2(GRID_ROWS) + 1 : 7;
	localparam int HALF  = GRID_COLS / 2;

	localparam logic signed [DXW-1:0] HALF_S = DXW'(HALF);
	localparam logic signed [DXW-1:0] WIDE_S = DXW'(GRID_COLS);
	localparam logic [XW-1:0]         X_W    = XW'(GRID_COLS);
	localparam logic [XW-1:0]         X_TOP  = XW'(GRID_COLS - 1);
	localparam logic signed [YW-1:0]  Y_TOP  = YW'(GRID_ROWS - 1);

	logic signed [DXW-1:0]   dx_q;
	logic signed [5:0]       dy_q;
	logic [XW-1:0]           x_q;
	logic signed [YW-1:0]    y_q;
	logic [SW-1:0]           steps_q;
	logic [STEP_W-1:0]       last_q;
	logic [STEP_W-1:0]       s_q;
	logic signed [RW-1:0]    rx_q;
	logic signed [RW-1:0]    ry_q;
	point_t                  point_q;

	logic [SW-1:0]           adx;
	logic [SW-1:0]           ady;
	logic [SW-1:0]           steps;
	logic signed [RW-1:0]    two_steps;
	logic signed [RW-1:0]    dx2;
	logic signed [RW-1:0]    dy2;
	logic signed [RW-1:0]    rx_sum;
	logic signed [RW-1:0]    ry_sum;
	logic signed [RW-1:0]    rx_nxt;
	logic signed [RW-1:0]    ry_nxt;
	logic [XW-1:0]           x_nxt;
	logic signed [YW-1:0]    y_nxt;
	logic signed [YW-1:0]    y_clamp;

	always_comb begin
		adx   = (dx_q < 0) ? SW'(-dx_q) : SW'(dx_q);
		ady   = (dy_q < 0) ? SW'(-dy_q) : SW'(dy_q);
		steps = (adx > ady) ? adx : ady;
	end

	// One step of the exact rounding: the remainder stays in [0, 2*steps), and
	// since |delta| <= steps one correction per step is enough.
	always_comb begin
		two_steps = RW'({steps_q, 1'b0});
		dx2       = RW'(dx_q) <<< 1;
		dy2       = RW'(dy_q) <<< 1;
		rx_sum    = rx_q + dx2;
		ry_sum    = ry_q + dy2;
		rx_nxt    = rx_sum;
		x_nxt     = x_q;
		if (rx_sum >= two_steps) begin
			rx_nxt = rx_sum - two_steps;
			x_nxt  = (x_q == X_TOP) ? '0 : x_q + 1'b1;
		end else if (rx_sum < 0) begin
			rx_nxt = rx_sum + two_steps;
			x_nxt  = (x_q == '0) ? X_TOP : x_q - 1'b1;
		end
		ry_nxt = ry_sum;
		y_nxt  = y_q;
		if (ry_sum >= two_steps) begin
			ry_nxt = ry_sum - two_steps;
			y_nxt  = y_q + 1'b1;
		end else if (ry_sum < 0) begin
			ry_nxt = ry_sum + two_steps;
			y_nxt  = y_q - 1'b1;
		end
	end

	always_comb begin
		if (y_q < 0) begin
			y_clamp = '0;
		end else if (y_q > Y_TOP) begin
			y_clamp = Y_TOP;
		end else begin
			y_clamp = y_q;
		end
	end

	assign status.x_ok = (x_q < X_W);
	assign status.last = (s_q == last_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= DXW'($signed({1'b0, line.end_x})) -
				DXW'($signed({1'b0, line.start_x}));
			dy_q <= $signed({1'b0, line.end_y}) - $signed({1'b0, line.start_y});
			x_q  <= XW'(line.start_x);
			y_q  <= YW'({1'b0, line.start_y});
		end
		if (cmd.delta) begin
			if (dx_q > HALF_S) begin
				dx_q <= dx_q - WIDE_S;
			end else if (dx_q < -HALF_S) begin
				dx_q <= dx_q + WIDE_S;
			end
		end
		if (cmd.reduce && (x_q >= X_W)) begin
			x_q <= x_q - X_W;
		end
		if (cmd.span) begin
			steps_q <= steps;
			rx_q    <= RW'(steps);
			ry_q    <= RW'(steps);
			s_q     <= '0;
			last_q  <= (steps > SW'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(steps);
		end
		if (cmd.step) begin
			point_q.point_x     <= x_q[COL_W-1:0];
			point_q.point_y     <= y_clamp[ROW_W-1:0];
			point_q.step_number <= s_q;
			point_q.is_last     <= status.last;
			s_q                 <= s_q + 1'b1;
			rx_q                <= rx_nxt;
			ry_q                <= ry_nxt;
			x_q                 <= x_nxt;
			y_q                 <= y_nxt;
		end
	end

	assign point = point_q;

endmodule

@@ hdl/wrapped_line_rasterizer.sv @@
// Traces a line between two grid points on a map that wraps horizontally and
// emits its points one transfer at a time, in order, with the index of each
// point and a mark on the final one. The column difference takes the shorter
// way round the map, the number of steps is the larger of the absolute column
// and row differences, and each point is rounded exactly to the nearest cell
// with ties toward plus infinity; columns wrap and rows clamp to the map.
// A line passes through the input transfer, a state that picks the wrap
// direction and a state that finds the step count, then yields one point per
// cycle through the single-step rounding unit while the output is not stalled.
// When GRID_COLS is below 64 the start column is first reduced modulo the
// width by repeated subtraction; every subtraction after the first holds the
// block in its reduce state before the points begin.
// A line longer than 32 steps is cut after step 32. The next line is taken in
// the cycle after its last point enters the output register, while that point
// still waits to be taken.
module wrapped_line_rasterizer #(
	parameter int GRID_COLS = wlr_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = wlr_pkg::GRID_ROWS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            line_valid,
	output logic            line_stall,
	input  wlr_pkg::line_t  line,
	output logic            point_valid,
	input  logic            point_stall,
	output wlr_pkg::point_t point
);
	import wlr_pkg::*;

	// Commands flow from the controller, status flows back.
	wlr_cmd_t    cmd;
	wlr_status_t status;

	wlr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.line_valid  (line_valid),
		.line_stall  (line_stall),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.status      (status),
		.cmd         (cmd)
	);

	// The datapath holds the deltas, the two rounding remainders, the current
	// wrapped column and unclamped row, and the output register.
	wlr_datapath #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_datapath (
		.clk    (clk),
		.cmd    (cmd),
		.line   (line),
		.status (status),
		.point  (point)
	);

endmodule

@@ hdl/wlr_checker.sv @@
module wlr_checker #(
	parameter int GRID_ROWS = wlr_pkg::GRID_ROWS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            line_valid,
	input logic            line_stall,
	input logic            point_valid,
	input logic            point_stall,
	input wlr_pkg::point_t point
);
	import wlr_pkg::*;

	// A line transfer always occupies the block for at least the next cycle.
	a_busy_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		line_valid && !line_stall |=> line_stall)
		else $error("line taken while the block was not busy afterwards");

	// A stalled point holds its place.
	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_stall |=> point_valid && $stable(point))
		else $error("stalled point changed or vanished");

	// Points of one line follow each other without a gap, counting up by one.
	a_point_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_stall && !point.is_last |=>
		point_valid && (point.step_number == $past(point.step_number) + 1'b1))
		else $error("point sequence broken");

	// The step index never passes the cut, and the cut always ends the line.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> (point.step_number < STEP_W'(MAX_STEPS)) ||
		((point.step_number == STEP_W'(MAX_STEPS)) && point.is_last))
		else $error("step index beyond the end of the line");

	// Rows are clamped to the map.
	a_row_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> (32'(point.point_y) <= 32'(GRID_ROWS - 1)))
		else $error("row outside the map");

endmodule

bind wrapped_line_rasterizer wlr_checker #(
	.GRID_ROWS (GRID_ROWS)
) u_wlr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.line_valid  (line_valid),
	.line_stall  (line_stall),
	.point_valid (point_valid),
	.point_stall (point_stall),
	.point       (point)
);
